/* rtl/core/chtd_pkg.sv */
// chtd_pkg: shared types and constants of the cheat code text decoder
// used by chtd_store, chtd_decode and cheat_code_text_decoder_core
package chtd_pkg;

  localparam int unsigned Slots  = 11;
  localparam int unsigned PosSat = 12;

  // bit positions inside the separator record
  localparam int unsigned SepDash3  = 0;
  localparam int unsigned SepColon4 = 1;
  localparam int unsigned SepColon7 = 2;
  localparam int unsigned SepDash7  = 3;

  typedef enum logic [2:0] {
    FMT_NONE        = 3'd0,
    FMT_COLON_SHORT = 3'd1,
    FMT_COLON_CMP   = 3'd2,
    FMT_DASH_SHORT  = 3'd3,
    FMT_DASH_CMP    = 3'd4
  } format_e;

  // store contents as seen by the decoder, current character included
  typedef struct packed {
    logic [3:0]             len;
    logic [3:0]             sep;
    logic [Slots-1:0][3:0]  digits;
    logic [Slots-1:0]       marks;
  } store_view_t;

  typedef struct packed {
    logic       code_ok;
    format_e    format_kind;
    logic [15:0] target_address;
    logic [7:0]  new_value;
    logic [7:0]  compare_value;
    logic        has_compare;
  } result_t;

endpackage

/* rtl/core/chtd_store.sv */
// chtd_store: character position counter, nibble store, non-hex marks, separator record
// depends on chtd_pkg
module chtd_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output chtd_pkg::store_view_t view_o
);

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;

  logic [3:0] pos_q, pos_d, pos_inc;
  logic [3:0] sep_q, sep_d, sep_next;
  logic [chtd_pkg::Slots-1:0][3:0] digits_q;
  logic [chtd_pkg::Slots-1:0]      marks_q;
  logic [7:0] up_char;
  logic [3:0] nib;
  logic       bad;
  logic       in_range;

  always_comb begin
    // fold lower case to upper case
    if (char_i >= 8'h61 && char_i <= 8'h7A) begin
      up_char = char_i - 8'd32;
    end else begin
      up_char = char_i;
    end
    if (up_char >= 8'h30 && up_char <= 8'h39) begin
      nib = 4'(up_char - 8'h30);
      bad = 1'b0;
    end else if (up_char >= 8'h41 && up_char <= 8'h46) begin
      nib = 4'(up_char - 8'h37);
      bad = 1'b0;
    end else begin
      nib = 4'd0;
      bad = 1'b1;
    end
  end

  assign in_range = (pos_q < 4'(chtd_pkg::Slots));
  assign pos_inc  = (pos_q < 4'(chtd_pkg::PosSat)) ? pos_q + 4'd1 : pos_q;

  always_comb begin
    sep_next = sep_q;
    if (in_range) begin
      if (pos_q == 4'd3 && up_char == ChDash)  sep_next[chtd_pkg::SepDash3]  = 1'b1;
      if (pos_q == 4'd4 && up_char == ChColon) sep_next[chtd_pkg::SepColon4] = 1'b1;
      if (pos_q == 4'd7 && up_char == ChColon) sep_next[chtd_pkg::SepColon7] = 1'b1;
      if (pos_q == 4'd7 && up_char == ChDash)  sep_next[chtd_pkg::SepDash7]  = 1'b1;
    end
  end

  always_comb begin
    view_o.len    = pos_inc;
    view_o.sep    = sep_next;
    view_o.digits = digits_q;
    view_o.marks  = marks_q;
    if (in_range) begin
      view_o.digits[pos_q] = nib;
      view_o.marks[pos_q]  = bad;
    end
  end

  assign pos_d = last_i ? 4'd0 : pos_inc;
  assign sep_d = last_i ? 4'd0 : sep_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      sep_q <= 4'd0;
    end else if (adv_i) begin
      pos_q <= pos_d;
      sep_q <= sep_d;
    end
  end

  // entries are read only below the current length, so no reset
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      digits_q <= view_o.digits;
      marks_q  <= view_o.marks;
    end
  end

endmodule

/* rtl/core/chtd_decode.sv */
// chtd_decode: layout match and field assembly for one finished code
// depends on chtd_pkg
module chtd_decode (
  input  chtd_pkg::store_view_t view_i,
  output chtd_pkg::result_t     result_o
);

  logic [3:0] d [chtd_pkg::Slots];
  logic [chtd_pkg::Slots-1:0] m;
  logic bad_cs, bad_cc, bad_ds, bad_dc;
  logic [7:0] raw;

  always_comb begin
    for (int i = 0; i < int'(chtd_pkg::Slots); i++) begin
      d[i] = view_i.digits[i];
    end
  end
  assign m = view_i.marks;

  assign bad_cs = m[0] | m[1] | m[2] | m[3] | m[5] | m[6];
  assign bad_cc = bad_cs | m[8] | m[9];
  assign bad_ds = m[0] | m[1] | m[2] | m[4] | m[5] | m[6];
  assign bad_dc = bad_ds | m[8] | m[10];
  assign raw    = {d[8], d[10]};

  always_comb begin
    result_o = '0;
    result_o.format_kind = chtd_pkg::FMT_NONE;
    if (view_i.len == 4'd7 && view_i.sep[chtd_pkg::SepColon4]) begin
      if (!bad_cs) begin
        result_o.code_ok        = 1'b1;
        result_o.format_kind    = chtd_pkg::FMT_COLON_SHORT;
        result_o.target_address = {d[0], d[1], d[2], d[3]};
        result_o.new_value      = {d[5], d[6]};
      end
    end else if (view_i.len == 4'd10 && view_i.sep[chtd_pkg::SepColon4]
                 && view_i.sep[chtd_pkg::SepColon7]) begin
      if (!bad_cc) begin
        result_o.code_ok        = 1'b1;
        result_o.format_kind    = chtd_pkg::FMT_COLON_CMP;
        result_o.target_address = {d[0], d[1], d[2], d[3]};
        result_o.new_value      = {d[5], d[6]};
        result_o.compare_value  = {d[8], d[9]};
        result_o.has_compare    = 1'b1;
      end
    end else if (view_i.len == 4'd7 && view_i.sep[chtd_pkg::SepDash3]) begin
      if (!bad_ds) begin
        result_o.code_ok        = 1'b1;
        result_o.format_kind    = chtd_pkg::FMT_DASH_SHORT;
        result_o.new_value      = {d[0], d[1]};
        result_o.target_address = {d[6], d[2], d[4], d[5]} ^ 16'hF000;
      end
    end else if (view_i.len == 4'd11 && view_i.sep[chtd_pkg::SepDash3]
                 && view_i.sep[chtd_pkg::SepDash7]) begin
      if (!bad_dc) begin
        result_o.code_ok        = 1'b1;
        result_o.format_kind    = chtd_pkg::FMT_DASH_CMP;
        result_o.new_value      = {d[0], d[1]};
        result_o.target_address = {d[6], d[2], d[4], d[5]} ^ 16'hF000;
        result_o.compare_value  = {raw[1:0], raw[7:2]} ^ 8'hBA;
        result_o.has_compare    = 1'b1;
      end
    end
  end

endmodule

/* rtl/core/cheat_code_text_decoder_core.sv */
// cheat_code_text_decoder_core: top level of the cheat code text decoder
// depends on chtd_pkg, chtd_store, chtd_decode
//
// channel   dir  tdata                      tuser
// s_axis    in   [7:0] char_code            -        (tlast = is_last)
// m_axis    out  [15:0] target_address,     [0] code_ok, [3:1] format_kind,
//                [23:16] new_value,         [4] has_compare
//                [31:24] compare_value
//
// one character beat per cycle unless a final character is held back by a stalled
// result; a result passes the input register, then store update and decode into
// the output register
// reset clears the character position, the separator record and all valid flags
// a stalled result only holds back a final character; other characters flow on
module cheat_code_text_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] target_address, [23:16] new_value,
                                      // [31:24] compare_value
  output logic [4:0]  m_axis_tuser    // [0] code_ok, [3:1] format_kind, [4] has_compare
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_adv;

  // output register
  logic              out_valid_q, out_valid_d;
  chtd_pkg::result_t out_q;
  chtd_pkg::result_t dec_result;
  chtd_pkg::store_view_t view;
  logic              out_load;

  // a character leaves the input register unless it is final and the result
  // slot is still occupied
  assign s1_adv   = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready);
  assign out_load = s1_adv && s1_last_q;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign s1_valid_d  = (s_axis_tvalid && s_axis_tready) ? 1'b1
                     : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? 1'b1 : ((m_axis_tready) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_char_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_q <= dec_result;
    end
  end

  // position counter, nibble store and separator record
  chtd_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .char_i (s1_char_q),
    .last_i (s1_last_q),
    .view_o (view)
  );

  // layout match on the store contents including the final character
  chtd_decode u_decode (
    .view_i   (view),
    .result_o (dec_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.compare_value, out_q.new_value, out_q.target_address};
  assign m_axis_tuser  = {out_q.has_compare, out_q.format_kind, out_q.code_ok};

  // input side stalls only behind a final character waiting on a full result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // an invalid code carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0 && m_axis_tuser == 5'd0))
    else $error("invalid result with nonzero fields");

  // compare flag follows the compare formats
  a_compare_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[4] == (m_axis_tuser[3:1] == chtd_pkg::FMT_COLON_CMP ||
                           m_axis_tuser[3:1] == chtd_pkg::FMT_DASH_CMP)) &&
      (m_axis_tuser[3:1] != chtd_pkg::FMT_NONE))
    else $error("format and compare flag disagree");

  // a result is valid in the cycle after a final character leaves the input register
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result lost after final character");

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for cheat_code_text_decoder_core
// drives character beats, predicts each decoded code and checks the result beats
// depends on chtd_pkg and the rtl of the decoder core
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] target_address, [23:16] new_value,
                               // [31:24] compare_value
  logic [4:0]  m_axis_tuser;   // [0] code_ok, [3:1] format_kind, [4] has_compare

  cheat_code_text_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // directed codes; typed rows carry their decode, the others use the predictor
  typedef struct {
    string             txt;
    bit                typed;
    chtd_pkg::result_t want;
  } code_row_t;

  code_row_t dir_rows [12] = '{
    '{"1234:56",       1'b1,
      '{1'b1, chtd_pkg::FMT_COLON_SHORT, 16'h1234, 8'h56, 8'h00, 1'b0}},
    '{"FFFF:FF:FF",    1'b1,
      '{1'b1, chtd_pkg::FMT_COLON_CMP,   16'hFFFF, 8'hFF, 8'hFF, 1'b1}},
    '{"0000:00",       1'b1,
      '{1'b1, chtd_pkg::FMT_COLON_SHORT, 16'h0000, 8'h00, 8'h00, 1'b0}},
    '{"abcd:ef:09",    1'b0, '0},  // lower case folded
    '{"123-456",       1'b0, '0},
    '{"FfF-000-8z9",   1'b0, '0},  // tenth character not checked
    '{"12g4:56",       1'b1, '0},  // non-hex digit inside a matched layout
    '{"123-:56",       1'b1, '0},  // colon layout wins, its dash is a bad digit
    '{"1234-56",       1'b1, '0},  // no layout matches
    '{"1234:56:7",     1'b1, '0},  // wrong length
    '{"123456789ABCD", 1'b1, '0},  // overlong, position saturates
    '{"A",             1'b1, '0}   // single character code
  };

  // predictor state
  logic [3:0] char_cnt;
  logic [3:0] nib [chtd_pkg::Slots];
  logic       non_hex [chtd_pkg::Slots];
  logic [3:0] sep_seen;

  chtd_pkg::result_t decode_q [$];   // decoded codes still waiting for their result beat
  int      mismatch_cnt = 0;
  int      burst_left;     // sender beats left in a no-gap stretch
  int      ready_hold = 0; // receiver cycles left at the current ready level

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // store one character and, on the last one, decode the whole code
  function automatic chtd_pkg::result_t take_char(input logic [7:0] raw, input bit last);
    logic [7:0]        c;
    logic [7:0]        cmp_raw;
    chtd_pkg::result_t r;
    c = (raw >= "a" && raw <= "z") ? raw - 8'd32 : raw;
    r = '0;
    if (char_cnt < 4'(chtd_pkg::Slots)) begin
      if (c >= "0" && c <= "9") begin
        nib[char_cnt]     = 4'(c - "0");
        non_hex[char_cnt] = 1'b0;
      end else if (c >= "A" && c <= "F") begin
        nib[char_cnt]     = 4'(c - "A" + 8'd10);
        non_hex[char_cnt] = 1'b0;
      end else begin
        nib[char_cnt]     = 4'd0;
        non_hex[char_cnt] = 1'b1;
      end
      if (char_cnt == 4'd3 && c == "-") sep_seen[chtd_pkg::SepDash3] = 1'b1;
      if (char_cnt == 4'd4 && c == ":") sep_seen[chtd_pkg::SepColon4] = 1'b1;
      if (char_cnt == 4'd7 && c == ":") sep_seen[chtd_pkg::SepColon7] = 1'b1;
      if (char_cnt == 4'd7 && c == "-") sep_seen[chtd_pkg::SepDash7] = 1'b1;
    end
    if (char_cnt < 4'(chtd_pkg::PosSat)) char_cnt++;
    if (!last) return r;

    // layouts tried in order; the first one matching on length and separators decides
    if (char_cnt == 4'd7 && sep_seen[chtd_pkg::SepColon4]) begin
      if (!(non_hex[0] | non_hex[1] | non_hex[2] | non_hex[3] | non_hex[5] |
            non_hex[6])) begin
        r.code_ok        = 1'b1;
        r.format_kind    = chtd_pkg::FMT_COLON_SHORT;
        r.target_address = {nib[0], nib[1], nib[2], nib[3]};
        r.new_value      = {nib[5], nib[6]};
      end
    end else if (char_cnt == 4'd10 && sep_seen[chtd_pkg::SepColon4] &&
                 sep_seen[chtd_pkg::SepColon7]) begin
      if (!(non_hex[0] | non_hex[1] | non_hex[2] | non_hex[3] | non_hex[5] |
            non_hex[6] | non_hex[8] | non_hex[9])) begin
        r.code_ok        = 1'b1;
        r.format_kind    = chtd_pkg::FMT_COLON_CMP;
        r.target_address = {nib[0], nib[1], nib[2], nib[3]};
        r.new_value      = {nib[5], nib[6]};
        r.compare_value  = {nib[8], nib[9]};
        r.has_compare    = 1'b1;
      end
    end else if (char_cnt == 4'd7 && sep_seen[chtd_pkg::SepDash3]) begin
      if (!(non_hex[0] | non_hex[1] | non_hex[2] | non_hex[4] | non_hex[5] |
            non_hex[6])) begin
        r.code_ok        = 1'b1;
        r.format_kind    = chtd_pkg::FMT_DASH_SHORT;
        r.new_value      = {nib[0], nib[1]};
        r.target_address = {nib[6], nib[2], nib[4], nib[5]} ^ 16'hF000;
      end
    end else if (char_cnt == 4'd11 && sep_seen[chtd_pkg::SepDash3] &&
                 sep_seen[chtd_pkg::SepDash7]) begin
      if (!(non_hex[0] | non_hex[1] | non_hex[2] | non_hex[4] | non_hex[5] |
            non_hex[6] | non_hex[8] | non_hex[10])) begin
        cmp_raw          = {nib[8], nib[10]};
        r.code_ok        = 1'b1;
        r.format_kind    = chtd_pkg::FMT_DASH_CMP;
        r.new_value      = {nib[0], nib[1]};
        r.target_address = {nib[6], nib[2], nib[4], nib[5]} ^ 16'hF000;
        r.compare_value  = {cmp_raw[1:0], cmp_raw[7:2]} ^ 8'hBA;  // rotate right by 2
        r.has_compare    = 1'b1;
      end
    end
    char_cnt = 4'd0;
    sep_seen = 4'd0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // one character beat, after a random gap; the decode is taken at the handshake
  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input chtd_pkg::result_t want);
    int                gap;
    int                p;
    chtd_pkg::result_t pred;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 20) burst_left = $urandom_range(10, 60);
      else if (p < 85) gap = $urandom_range(0, 2);
      else if (p < 95) gap = $urandom_range(3, 8);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = take_char(c, last);
    if (last) decode_q.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // receiver: ready stretches, short stalls and the odd long stall
  always @(negedge clk_i) begin
    int p;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold == 0) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(1, 40);
      end else if (p < 90) begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end else begin
      ready_hold--;
    end
  end

  // result beats against the oldest decoded code
  always @(posedge clk_i) begin
    chtd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decode_q.size() == 0) begin
        $error("result beat with no decoded code waiting");
        mismatch_cnt++;
      end else begin
        want = decode_q.pop_front();
        check_field("code_ok", 16'(want.code_ok), 16'(m_axis_tuser[0]));
        check_field("format_kind", 16'(want.format_kind), 16'(m_axis_tuser[3:1]));
        check_field("target_address", want.target_address, m_axis_tdata[15:0]);
        check_field("new_value", 16'(want.new_value), 16'(m_axis_tdata[23:16]));
        check_field("compare_value", 16'(want.compare_value), 16'(m_axis_tdata[31:24]));
        check_field("has_compare", 16'(want.has_compare), 16'(m_axis_tuser[4]));
      end
    end
  end

  initial begin
    byte unsigned code [$];
    string        pat;
    string        hex_set;
    string        mix_set;
    int           shape;
    int           n;
    int           chars_sent;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    char_cnt      = 4'd0;
    sep_seen      = 4'd0;
    for (int k = 0; k < chtd_pkg::Slots; k++) begin
      nib[k]     = 4'd0;
      non_hex[k] = 1'b0;
    end
    burst_left   = 0;
    chars_sent   = 0;
    hex_set      = "0123456789abcdefABCDEF";
    mix_set      = "0123456789ABCDEF:-a";
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed codes
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].txt.len(); i++) begin
        send_char(dir_rows[r].txt[i], i == dir_rows[r].txt.len() - 1,
                  dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random codes: mostly well-formed layouts, some corrupted, some noise
    while (chars_sent < 450) begin
      code.delete();
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
        case ($urandom_range(0, 3))
          0: begin
            pat = "HHHH:HH";
          end
          1: begin
            pat = "HHHH:HH:HH";
          end
          2: begin
            pat = "HHH-HHH";
          end
          default: begin
            pat = "HHH-HHH-HxH";
          end
        endcase
        for (int i = 0; i < pat.len(); i++) begin
          if (pat[i] == "H") code.push_back(hex_set[$urandom_range(0, 21)]);
          else if (pat[i] == "x") code.push_back(8'($urandom_range(0, 255)));
          else code.push_back(pat[i]);
        end
        if ($urandom_range(0, 5) == 0)
          code[$urandom_range(0, code.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        // noise codes, a few of them overlong
        n = (shape < 92) ? $urandom_range(1, 11) : $urandom_range(12, 16);
        repeat (n) begin
          if ($urandom_range(0, 1) == 1)
            code.push_back(mix_set[$urandom_range(0, mix_set.len() - 1)]);
          else
            code.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (int i = 0; i < code.size(); i++) begin
        send_char(code[i], i == code.size() - 1, 1'b0, '0);
      end
      chars_sent += code.size();
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching to catch any stray result beat
    wait (decode_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
